// File: hw/rtl/pss_pkg.sv
package pss_pkg;

    // Store geometry
    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    // Field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int SUM_W  = DATA_W + 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted element or flag overflow
        logic latch_a;     // capture row element, start column at i+1
        logic step_j;      // advance column
        logic next_i;      // advance row
        logic record_hit;  // capture the matching pair
        logic finish;      // result taken, clear list state
    } pss_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic row_open;    // i + 1 < count
        logic more_j;      // j + 1 < count
        logic hit;         // a + store[j] == target
    } pss_status_t;

endpackage

// File: hw/rtl/pss_ifs.sv
// Input channel: one list element per transaction
interface pss_in_if
    import pss_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// Output channel: one search result per transaction
interface pss_out_if
    import pss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             overflowed;

    modport source (output valid, output found, output first_index,
                    output second_index, output overflowed, input ready);
    modport sink   (input valid, input found, input first_index,
                    input second_index, input overflowed, output ready);
endinterface

// File: hw/rtl/pss_datapath.sv
module pss_datapath
    import pss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pss_cmd_t                 cmd,
    output pss_status_t              status,
    input  logic                     cfg_wr_en,
    input  logic signed [DATA_W-1:0] cfg_wr_data,
    input  logic signed [DATA_W-1:0] in_value,
    output logic                     res_found,
    output logic [IDX_W-1:0]         res_first_index,
    output logic [IDX_W-1:0]         res_second_index,
    output logic                     res_overflowed
);

    // Element store
    logic [DATA_W-1:0] element_store [MAX_ELEMENTS];
    logic [DATA_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    logic signed [DATA_W-1:0] target_reg, target_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [ADDR_W-1:0]        i_reg, i_next;
    logic [ADDR_W-1:0]        j_reg, j_next;
    logic                     found_reg, found_next;
    logic [ADDR_W-1:0]        first_reg, first_next;
    logic [ADDR_W-1:0]        second_reg, second_next;

    logic                     store_full;
    logic signed [SUM_W-1:0]  pair_sum;

    assign store_full = (count_reg >= COUNT_W'(MAX_ELEMENTS));
    assign wr_en      = cmd.load && !store_full;

    // Read address: row element, first column, or next column
    always_comb
    begin
        priority if (cmd.latch_a)
        begin
            rd_addr = i_reg + ADDR_W'(1);
        end
        else if (cmd.step_j)
        begin
            rd_addr = j_reg + ADDR_W'(1);
        end
        else
        begin
            rd_addr = i_reg;
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            element_store[count_reg[ADDR_W-1:0]] <= in_value;
        end
        rdata_reg <= element_store[rd_addr];
    end

    // 33-bit pair sum against the target
    assign pair_sum = SUM_W'(a_reg) + SUM_W'($signed(rdata_reg));

    assign status.row_open = ((COUNT_W'(i_reg) + COUNT_W'(1)) < count_reg);
    assign status.more_j   = ((COUNT_W'(j_reg) + COUNT_W'(1)) < count_reg);
    assign status.hit      = (pair_sum == SUM_W'(target_reg));

    // Next-state logic
    always_comb
    begin
        target_next = target_reg;
        a_next      = a_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        second_next = second_reg;

        if (cfg_wr_en)
        begin
            target_next = cfg_wr_data;
        end

        if (cmd.load)
        begin
            if (store_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end

        if (cmd.latch_a)
        begin
            a_next = $signed(rdata_reg);
            j_next = i_reg + ADDR_W'(1);
        end

        if (cmd.step_j)
        begin
            j_next = j_reg + ADDR_W'(1);
        end

        if (cmd.next_i)
        begin
            i_next = i_reg + ADDR_W'(1);
        end

        if (cmd.record_hit)
        begin
            found_next  = 1'b1;
            first_next  = i_reg;
            second_next = j_reg;
        end

        if (cmd.finish)
        begin
            count_next  = '0;
            ovf_next    = 1'b0;
            i_next      = '0;
            found_next  = 1'b0;
            first_next  = '0;
            second_next = '0;
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            found_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            found_reg  <= found_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Search operands
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        j_reg <= j_next;
    end

    assign res_found        = found_reg;
    assign res_first_index  = IDX_W'(first_reg);
    assign res_second_index = IDX_W'(second_reg);
    assign res_overflowed   = ovf_reg;

endmodule

// File: hw/rtl/pss_ctrl.sv
module pss_ctrl
    import pss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  pss_status_t status,
    output pss_cmd_t    cmd
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_RD_A   = 3'd1;
    localparam logic [2:0] ST_LD_A   = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_RESULT);

    // Sequencer: load, then walk rows and columns
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A:
            begin
                // row element read is issued here by default address
                if (status.row_open)
                begin
                    state_next = ST_LD_A;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_LD_A:
            begin
                cmd.latch_a = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (status.hit)
                begin
                    cmd.record_hit = 1'b1;
                    state_next     = ST_RESULT;
                end
                else if (status.more_j)
                begin
                    cmd.step_j = 1'b1;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                    state_next = ST_RD_A;
                end
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/pair_sum_index_search.sv
// Channel   Dir  Transaction payload
// in_item   in   value (s32), last
// out_item  out  found, first_index (10b), second_index (10b), overflowed
// cfg       in   cfg_wr_en, cfg_wr_data = target_sum (s32)
//
// Elements load one per cycle; the transaction with last is taken at once and
// the search starts on the next cycle. Each row of the search reads and
// latches its row element, then compares the columns after it in turn, a
// walk set by the single read port of the element store.
// The result is held on out_item until taken; input stays stalled from the
// start of the search until then.
// Reset clears counts, flags and target_sum; the store needs no clearing.
module pair_sum_index_search
    import pss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    pss_in_if.sink                   in_item,
    pss_out_if.source                out_item,
    input  logic                     cfg_wr_en,
    input  logic signed [DATA_W-1:0] cfg_wr_data
);

    pss_cmd_t    cmd;
    pss_status_t status;

    // Sequencer
    pss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_last   (in_item.last),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Store, operands and result registers
    pss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_value         (in_item.value),
        .res_found        (out_item.found),
        .res_first_index  (out_item.first_index),
        .res_second_index (out_item.second_index),
        .res_overflowed   (out_item.overflowed)
    );

endmodule

// File: dv/pair_sum_index_search_test.sv
`timescale 1ns / 1ps

module pair_sum_index_search_test
    import pss_pkg::*;
();

    localparam int RESET_CYCLES   = 9;
    localparam int GAP_MAX        = 16;
    localparam int IDLE_GUARD     = 8;
    localparam int TAIL_CYCLES    = 32;
    localparam int TOTAL_ITEMS    = 1400;
    localparam int MEDIUM_ITEMS   = 200;
    localparam int WATCHDOG_LIMIT = 200000;

    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] element_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             overflowed;
    } pair_result_t;

    // Mirror of the list store and the queue of search results still owed
    class pair_result_board;
        element_t     elements [MAX_ELEMENTS];
        int           stored;
        bit           dropped;
        element_t     target;
        pair_result_t expected_pairs [$];
        int           errors;

        function new();
            stored  = 0;
            dropped = 1'b0;
            target  = '0;
            errors  = 0;
        endfunction

        // First pair i < j, row-major, whose 33-bit sum hits the target
        function pair_result_t search_first_pair();
            pair_result_t            outcome;
            logic signed [SUM_W-1:0] goal;
            logic signed [SUM_W-1:0] row_val;
            logic signed [SUM_W-1:0] col_val;
            outcome = '0;
            goal    = target;
            for (int i = 0; i + 1 < stored && !outcome.found; i++)
            begin
                row_val = elements[i];
                for (int j = i + 1; j < stored; j++)
                begin
                    col_val = elements[j];
                    if (row_val + col_val == goal)
                    begin
                        outcome.found        = 1'b1;
                        outcome.first_index  = IDX_W'(i);
                        outcome.second_index = IDX_W'(j);
                        break;
                    end
                end
            end
            outcome.overflowed = dropped;
            return outcome;
        endfunction

        // Accepted input transaction
        function void note_element(element_t element, logic is_last);
            if (stored < MAX_ELEMENTS)
            begin
                elements[stored] = element;
                stored++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (is_last)
            begin
                expected_pairs.push_back(search_first_pair());
                stored  = 0;
                dropped = 1'b0;
            end
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        // Accepted output transaction
        function void check_result(pair_result_t got);
            pair_result_t want;
            if (expected_pairs.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing outstanding, expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_pairs.pop_front();
            if (got.found !== want.found)
                report_field("found", want.found, got.found);
            if (got.first_index !== want.first_index)
                report_field("first_index", want.first_index, got.first_index);
            if (got.second_index !== want.second_index)
                report_field("second_index", want.second_index, got.second_index);
            if (got.overflowed !== want.overflowed)
                report_field("overflowed", want.overflowed, got.overflowed);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void check_drained();
            if (expected_pairs.size() != 0)
            begin
                errors++;
                $display("%0t: %0d results outstanding, expected 0, actual %0d",
                         $time, expected_pairs.size(), expected_pairs.size());
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    element_t cfg_wr_data;

    pss_in_if  elem_if ();
    pss_out_if result_if ();

    pair_result_board board;
    int               elements_sent;
    int               idle_cycles;
    int               sink_gap;
    bit               src_steady;
    bit               sink_steady;

    pair_sum_index_search DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (elem_if),
        .out_item    (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Per-transaction stall; occasionally toggle into or out of a no-stall stretch
    function automatic int draw_gap(inout bit steady);
        if ($urandom_range(0, 47) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic element_t random_even();
        element_t v;
        v = $urandom;
        return v & ~element_t'(1);
    endfunction

    // Values within +/-2^29 so a partner can be formed without wrapping
    function automatic element_t quarter_range();
        element_t v;
        v = $urandom;
        return v >>> 2;
    endfunction

    function automatic element_t pick_target();
        element_t v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = VALUE_MAX;
            2: v = VALUE_MIN;
            3: v = -element_t'(1);
            4: v = element_t'(1);
            7: v = element_t'($urandom_range(0, 40)) - element_t'(20);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 12);
        else if (r < 97)
            return $urandom_range(13, 48);
        return $urandom_range(49, 120);
    endfunction

    // Mostly partners of earlier elements and values near half the target
    function automatic void build_random_list(input int len, input element_t goal,
                                              output element_t items [$]);
        element_t v;
        element_t half;
        int       pick;
        items = {};
        half  = goal >>> 1;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && k > 0)
                v = goal - items[$urandom_range(0, k - 1)];
            else if (pick < 55)
                v = half + element_t'($urandom_range(0, 16)) - element_t'(8);
            else if (pick < 75)
                v = $urandom;
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = '0;
                    default: v = -element_t'(1);
                endcase
            end
            else
                v = element_t'($urandom_range(0, 16)) - element_t'(8);
            items.push_back(v);
        end
    endfunction

    // One input transaction; valid stays up when the next one follows directly
    task automatic send_element(input element_t element, input logic is_last);
        int gap;
        gap = draw_gap(src_steady);
        if (gap > 0)
        begin
            elem_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_if.valid <= 1'b1;
        elem_if.value <= element;
        elem_if.last  <= is_last;
        do @(posedge clk); while (!elem_if.ready);
        elements_sent++;
    endtask

    task automatic send_list(input element_t items [$]);
        foreach (items[k])
            send_element(items[k], k == items.size() - 1);
    endtask

    // Target is only rewritten with no list open and no result owed
    task automatic write_target(input element_t goal);
        elem_if.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (IDLE_GUARD) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= goal;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.target = goal;
    endtask

    task automatic run_directed();
        element_t items [$];
        // reset target of zero: plain hit, then min+min which only wraps to zero
        items = '{element_t'(5), -element_t'(5)};
        send_list(items);
        items = '{VALUE_MIN, VALUE_MIN};
        send_list(items);
        // single element list has no pair
        items = '{element_t'(0)};
        send_list(items);
        write_target(VALUE_MAX);
        items = '{VALUE_MAX, element_t'(0), element_t'(1), VALUE_MAX - 1};
        send_list(items);
        write_target(VALUE_MIN);
        items = '{-element_t'(1), VALUE_MIN, element_t'(0), element_t'(7)};
        send_list(items);
        // max+max would hit -2 if the sum were only 32 bits wide
        write_target(-element_t'(2));
        items = '{VALUE_MAX, VALUE_MAX, -element_t'(1), element_t'(3), -element_t'(1)};
        send_list(items);
        // the first hit in row order, (0,2), is taken ahead of the later pair (1,3)
        write_target(element_t'(10));
        items = '{element_t'(5), element_t'(3), element_t'(5), element_t'(7)};
        send_list(items);
    endtask

    task automatic run_full_store();
        element_t items [$];
        element_t goal;
        element_t head;
        element_t v;

        // Overflow by one, the last element itself dropped:
        // hit between slot 0 and the top slot
        goal = quarter_range();
        head = quarter_range();
        write_target(goal);
        items = {head};
        for (int k = 1; k < MAX_ELEMENTS + 1; k++)
        begin
            v = $urandom;
            while (v == goal - head) v = $urandom;
            items.push_back(v);
        end
        items[MAX_ELEMENTS-1] = goal - head;
        send_list(items);

        // Medium list with no hit at all: odd target, even elements, full search
        write_target(quarter_range() | element_t'(1));
        items = {VALUE_MIN, element_t'(0)};
        for (int k = 2; k < MEDIUM_ITEMS; k++)
            items.push_back(random_even());
        send_list(items);
    endtask

    task automatic run_random();
        element_t items [$];
        while (elements_sent < TOTAL_ITEMS)
        begin
            write_target(pick_target());
            repeat ($urandom_range(4, 12))
            begin
                build_random_list(pick_length(), board.target, items);
                send_list(items);
            end
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        elem_if.valid <= 1'b0;
        elem_if.value <= '0;
        elem_if.last  <= 1'b0;
        board          = new();
        elements_sent  = 0;
        src_steady     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_full_store();
        run_random();

        elem_if.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        board.check_drained();
        if (board.errors == 0)
            $display("** pair_sum_index_search: PASSED **");
        else
            $display("** pair_sum_index_search: FAILED **");
        $finish;
    end

    // Result sink with random stalls
    initial
    begin
        result_if.ready <= 1'b0;
        sink_steady      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            sink_gap = draw_gap(sink_steady);
            if (sink_gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (sink_gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    // Monitor: input transaction first, so a result taken on the same edge finds it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (elem_if.valid && elem_if.ready)
                board.note_element(elem_if.value, elem_if.last);
            if (result_if.valid && result_if.ready)
                board.check_result('{result_if.found, result_if.first_index,
                                     result_if.second_index, result_if.overflowed});
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (elem_if.valid && elem_if.ready) ||
            (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("** pair_sum_index_search: FAILED **");
                $finish;
            end
        end
    end

endmodule
